// ----- rtl/olds_pkg.sv -----
// Shared constants, codes and controller/datapath interface types for the ordered list block.
package olds_pkg;

  localparam int CAPACITY = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int LEN_W    = $clog2(CAPACITY + 1);
  localparam int OP_W     = 3;
  localparam int POS_W    = 5;
  localparam int VAL_W    = 16;
  localparam int SCORE_W  = 21;
  localparam int CMP_W    = (LEN_W > POS_W) ? LEN_W : POS_W;

  localparam logic [OP_W-1:0] OP_READ   = OP_W'(0);
  localparam logic [OP_W-1:0] OP_WRITE  = OP_W'(1);
  localparam logic [OP_W-1:0] OP_INSERT = OP_W'(2);
  localparam logic [OP_W-1:0] OP_REMOVE = OP_W'(3);
  localparam logic [OP_W-1:0] OP_APPEND = OP_W'(4);
  localparam logic [OP_W-1:0] OP_SCORE  = OP_W'(5);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_WALK,
    ST_DRAIN,
    ST_COMMIT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic capture;
    logic walk_init;
    logic rd_en;
    logic commit;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic need_walk;
    logic walk_last;
  } dp_sts_t;

endpackage

// ----- rtl/olds_ctrl.sv -----
// Controller state machine: sequences capture, slot walk, commit and result hand-off.
module olds_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  olds_pkg::dp_sts_t sts,
  output olds_pkg::dp_cmd_t cmd
);
  import olds_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_CHECK;
      ST_CHECK:  state_nxt = sts.need_walk ? ST_WALK : ST_COMMIT;
      ST_WALK:   if (sts.walk_last) state_nxt = ST_DRAIN;
      ST_DRAIN:  state_nxt = ST_COMMIT;
      ST_COMMIT: state_nxt = ST_EMIT;
      ST_EMIT:   if (slot_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_IDLE:   cmd.capture   = in_valid;
      ST_CHECK:  cmd.walk_init = 1'b1;
      ST_WALK:   cmd.rd_en     = 1'b1;
      ST_DRAIN:  ;
      ST_COMMIT: cmd.commit    = 1'b1;
      ST_EMIT:   cmd.emit      = slot_free;
      default:   ;
    endcase
  end

  assign out_valid_nxt = cmd.emit || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ----- rtl/olds_dp.sv -----
// Datapath: entry memory, length, slot walker, read-data processing and result registers.
module olds_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  olds_pkg::dp_cmd_t             cmd,
  output olds_pkg::dp_sts_t             sts,
  input  logic [olds_pkg::OP_W-1:0]     in_operation,
  input  logic [olds_pkg::POS_W-1:0]    in_position,
  input  logic [olds_pkg::VAL_W-1:0]    in_item_value,
  output logic [olds_pkg::VAL_W-1:0]    out_read_data,
  output logic                          out_accepted,
  output logic [olds_pkg::SCORE_W-1:0]  out_score,
  output logic [olds_pkg::LEN_W-1:0]    out_current_length
);
  import olds_pkg::*;

  logic [VAL_W-1:0]    mem [CAPACITY];
  logic [CAPACITY-1:0] vld_r;

  logic [OP_W-1:0]    op_r;
  logic [POS_W-1:0]   pos_r;
  logic [VAL_W-1:0]   val_r;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic [IDX_W-1:0]   cnt_r, end_r;
  logic               dir_dn_r;
  logic               rv_r, rvb_r;
  logic [IDX_W-1:0]   ridx_r;
  logic [VAL_W-1:0]   rmem_r;
  logic               found_r;
  logic [SCORE_W-1:0] acc_r;
  logic [VAL_W-1:0]   rdata_r;
  logic               ok_nxt;
  logic               ok_r;

  logic [VAL_W-1:0]   out_read_data_r;
  logic               out_accepted_r;
  logic [SCORE_W-1:0] out_score_r;
  logic [LEN_W-1:0]   out_current_length_r;

  logic               pos_lt_len, pos_le_len, not_full;
  logic [IDX_W-1:0]   start_idx, end_idx;
  logic               start_dn;
  logic [VAL_W-1:0]   want, rd_word, dev;
  logic               match;
  logic               we;
  logic [IDX_W-1:0]   wa;
  logic [VAL_W-1:0]   wd;

  assign pos_lt_len = CMP_W'(pos_r) <  CMP_W'(len_r);
  assign pos_le_len = CMP_W'(pos_r) <= CMP_W'(len_r);
  assign not_full   = len_r < LEN_W'(CAPACITY);

  // walk bounds per operation
  always_comb begin
    sts.need_walk = 1'b0;
    sts.walk_last = (cnt_r == end_r);
    start_idx     = '0;
    end_idx       = IDX_W'(CAPACITY - 1);
    start_dn      = 1'b0;
    case (op_r)
      OP_READ: begin
        sts.need_walk = pos_lt_len;
        start_idx     = IDX_W'(pos_r);
        end_idx       = IDX_W'(pos_r);
      end
      OP_INSERT: begin
        sts.need_walk = not_full && pos_lt_len;
        start_idx     = IDX_W'(len_r - LEN_W'(1));
        end_idx       = IDX_W'(pos_r);
        start_dn      = 1'b1;
      end
      OP_REMOVE: begin
        // when the list is not full, one slot past the length is read so the hole can be filled from it
        sts.need_walk = 1'b1;
        end_idx       = not_full ? IDX_W'(len_r) : IDX_W'(CAPACITY - 1);
      end
      OP_SCORE: sts.need_walk = 1'b1;
      default: ;
    endcase
  end

  // an entry never written still holds its reset value, slot plus one
  assign want    = VAL_W'(ridx_r) + VAL_W'(1);
  assign rd_word = rvb_r ? rmem_r : want;
  assign dev     = (rd_word >= want) ? (rd_word - want) : (want - rd_word);
  assign match   = !found_r && (LEN_W'(ridx_r) < len_r) && (rd_word == val_r);

  // single write port: shift writes during the walk, final write at commit
  always_comb begin
    we = 1'b0;
    wa = IDX_W'(pos_r);
    wd = val_r;
    if (rv_r) begin
      if (op_r == OP_INSERT) begin
        we = 1'b1;
        wa = ridx_r + IDX_W'(1);
        wd = rd_word;
      end else if (op_r == OP_REMOVE && found_r) begin
        we = 1'b1;
        wa = ridx_r - IDX_W'(1);
        wd = rd_word;
      end
    end else if (cmd.commit) begin
      case (op_r)
        OP_WRITE:  we = pos_lt_len;
        OP_INSERT: we = not_full && pos_le_len;
        OP_APPEND: begin
          we = not_full;
          wa = IDX_W'(len_r);
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    ok_nxt  = 1'b0;
    len_nxt = len_r;
    case (op_r)
      OP_READ:   ok_nxt = pos_lt_len;
      OP_WRITE:  ok_nxt = pos_lt_len;
      OP_INSERT: begin
        ok_nxt = not_full && pos_le_len;
        if (ok_nxt) len_nxt = len_r + LEN_W'(1);
      end
      OP_REMOVE: begin
        ok_nxt = found_r;
        if (found_r) len_nxt = len_r - LEN_W'(1);
      end
      OP_APPEND: begin
        ok_nxt = not_full;
        if (not_full) len_nxt = len_r + LEN_W'(1);
      end
      OP_SCORE:  ok_nxt = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (cmd.rd_en) rmem_r <= mem[cnt_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= LEN_W'(CAPACITY);
      vld_r <= '0;
      rv_r  <= 1'b0;
    end else begin
      rv_r <= cmd.rd_en;
      if (we) vld_r[wa] <= 1'b1;
      if (cmd.commit) len_r <= len_nxt;
    end
  end

  // accepted flag latched at commit
  always_ff @(posedge clk) begin
    if (cmd.commit) ok_r <= ok_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= in_operation;
      pos_r   <= in_position;
      val_r   <= in_item_value;
      found_r <= 1'b0;
      acc_r   <= '0;
      rdata_r <= '0;
    end else if (rv_r) begin
      case (op_r)
        OP_READ:   rdata_r <= rd_word;
        OP_REMOVE: if (match) found_r <= 1'b1;
        OP_SCORE:  acc_r <= acc_r + SCORE_W'(dev);
        default: ;
      endcase
    end
    if (cmd.walk_init) begin
      cnt_r    <= start_idx;
      end_r    <= end_idx;
      dir_dn_r <= start_dn;
    end else if (cmd.rd_en) begin
      cnt_r <= dir_dn_r ? cnt_r - IDX_W'(1) : cnt_r + IDX_W'(1);
    end
    if (cmd.rd_en) begin
      ridx_r <= cnt_r;
      rvb_r  <= vld_r[cnt_r];
    end
    if (cmd.emit) begin
      out_read_data_r      <= rdata_r;
      out_accepted_r       <= ok_r;
      out_score_r          <= acc_r;
      out_current_length_r <= len_r;
    end
  end

  assign out_read_data      = out_read_data_r;
  assign out_accepted       = out_accepted_r;
  assign out_score          = out_score_r;
  assign out_current_length = out_current_length_r;

endmodule

// ----- rtl/ordered_list_with_deviation_score.sv -----
// Steps: accept, check, slot walk, drain, commit, emit; write, append, a read past the length
// and an insert at the end skip walk and drain; insert walks down to the position, remove
// walks up to one slot past the length (the last slot when full), score walks all 32 slots.
// Throughput: one transaction in flight; the next is taken the cycle after the result is
// loaded into the output register, so the slot walk over the single-port memory sets the rate.
// Reset (rst_n low, synchronous): length = 32, every slot reads as its index plus one.
module ordered_list_with_deviation_score (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [olds_pkg::OP_W-1:0]     in_operation,
  input  logic [olds_pkg::POS_W-1:0]    in_position,
  input  logic [olds_pkg::VAL_W-1:0]    in_item_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [olds_pkg::VAL_W-1:0]    out_read_data,
  output logic                          out_accepted,
  output logic [olds_pkg::SCORE_W-1:0]  out_score,
  output logic [olds_pkg::LEN_W-1:0]    out_current_length
);
  import olds_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  olds_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  olds_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_operation       (in_operation),
    .in_position        (in_position),
    .in_item_value      (in_item_value),
    .out_read_data      (out_read_data),
    .out_accepted       (out_accepted),
    .out_score          (out_score),
    .out_current_length (out_current_length)
  );

endmodule
